FILE: rtl/ubtx_pkg.sv
// Shared types and constants of the USB bulk-IN transmit packetizer.
package ubtx_pkg;

  // Field widths of the item and result transactions.
  localparam int FUNC_W = 2;
  localparam int DATA_W = 8;
  localparam int SENT_W = 7;
  localparam int FILL_W = 10;

  // Function codes carried by an input transaction.
  localparam logic [FUNC_W-1:0] FN_PUSH = 2'd0;
  localparam logic [FUNC_W-1:0] FN_DONE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_KICK = 2'd2;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_READ,
    S_SEND,
    S_STAT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the input transaction
    logic write;       // store the pushed byte in the ring
    logic clear_busy;  // end the transfer in flight
    logic start_tx;    // start a packet: mark busy, clear the byte count
    logic mark_zlp;    // the status result asks for a zero-length packet
    logic read;        // fetch the next ring byte and advance the read pointer
    logic show_pkt;    // the result on the output carries a packet byte
  } ubtx_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              link_ok;    // link enabled and device configured
    logic              full;       // ring holds its maximum
    logic              empty;      // ring holds nothing
    logic              eow;        // end of write on the captured push
    logic              zlp_req;    // sent count is a nonzero packet multiple
    logic              in_flight;  // a transfer is in flight
    logic              cfg;        // configured flag of the captured item
    logic              last_byte;  // the byte on the output ends the packet
  } ubtx_stat_t;

endpackage

FILE: rtl/ubtx_in_if.sv
// Input item channel of the packetizer.
interface ubtx_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] data_byte;
  logic       end_of_write;
  logic [6:0] sent_count;
  logic       configured;

  modport source (
    output valid, func, data_byte, end_of_write, sent_count, configured,
    input  ready
  );
  modport sink (
    input  valid, func, data_byte, end_of_write, sent_count, configured,
    output ready
  );
endinterface

FILE: rtl/ubtx_out_if.sv
// Result channel of the packetizer.
interface ubtx_out_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic       pkt_valid;
  logic [7:0] pkt_byte;
  logic       zero_length;
  logic       last;
  logic [9:0] fill_level;
  logic       busy_flag;

  modport source (
    output valid, accepted, pkt_valid, pkt_byte, zero_length, last, fill_level,
           busy_flag,
    input  ready
  );
  modport sink (
    input  valid, accepted, pkt_valid, pkt_byte, zero_length, last, fill_level,
           busy_flag,
    output ready
  );
endinterface

FILE: rtl/ubtx_cfg_if.sv
// Configuration write channel carrying the link enable register.
interface ubtx_cfg_if;
  logic valid;
  logic ready;
  logic link_enabled;

  modport source (output valid, link_enabled, input ready);
  modport sink (input valid, link_enabled, output ready);
endinterface

FILE: rtl/usb_bulk_in_tx_packetizer.sv
// Top level of the USB bulk-IN transmit packetizer.
//
// in_ch carries one item per transaction: push a byte, report a completed
// IN transfer, or kick a transmit. Each item gives either one status result
// or one result per packet byte (up to MAX_PACKET) on out_ch, the final one
// with last set. cfg_ch writes link_enabled; it is always ready.
// Timing: the item is taken in S_IDLE and decided in the next cycle, in
// S_EVAL. A status result is then offered in S_STAT; a packet shows each
// byte in S_SEND after fetching it in S_READ through the registered read
// port of the ring memory, so the next byte is fetched only once the
// current one is taken. One item is handled at a time: in_ch is ready
// again in the cycle after the last result of an item is taken.
// While out_ch.ready is low the result is held unchanged.
// Synchronous reset empties the ring, clears busy and link_enabled; the
// ring memory itself is not cleared and needs no clearing pass.
module usb_bulk_in_tx_packetizer #(
  parameter int RING_DEPTH = 1024,
  parameter int MAX_PACKET = 64
) (
  input logic         clk,
  input logic         rst,
  ubtx_in_if.sink     in_ch,
  ubtx_out_if.source  out_ch,
  ubtx_cfg_if.sink    cfg_ch
);
  import ubtx_pkg::*;

  ubtx_cmd_t  cmd;
  ubtx_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  ubtx_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ubtx_dp #(
    .RING_DEPTH (RING_DEPTH),
    .MAX_PACKET (MAX_PACKET)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_we       (cfg_ch.valid & cfg_ch.ready),
    .cfg_link     (cfg_ch.link_enabled),
    .func         (in_ch.func),
    .data_byte    (in_ch.data_byte),
    .end_of_write (in_ch.end_of_write),
    .sent_count   (in_ch.sent_count),
    .configured   (in_ch.configured),
    .accepted     (out_ch.accepted),
    .pkt_valid    (out_ch.pkt_valid),
    .pkt_byte     (out_ch.pkt_byte),
    .zero_length  (out_ch.zero_length),
    .last         (out_ch.last),
    .fill_level   (out_ch.fill_level),
    .busy_flag    (out_ch.busy_flag)
  );

endmodule

FILE: rtl/ubtx_dp.sv
// Datapath of the packetizer: ring memory, pointers, busy flag and result fields.
module ubtx_dp #(
  parameter int RING_DEPTH = 1024,
  parameter int MAX_PACKET = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ubtx_pkg::ubtx_cmd_t           cmd,
  output ubtx_pkg::ubtx_stat_t          stat,
  input  logic                          cfg_we,
  input  logic                          cfg_link,
  input  logic [ubtx_pkg::FUNC_W-1:0]   func,
  input  logic [ubtx_pkg::DATA_W-1:0]   data_byte,
  input  logic                          end_of_write,
  input  logic [ubtx_pkg::SENT_W-1:0]   sent_count,
  input  logic                          configured,
  output logic                          accepted,
  output logic                          pkt_valid,
  output logic [ubtx_pkg::DATA_W-1:0]   pkt_byte,
  output logic                          zero_length,
  output logic                          last,
  output logic [ubtx_pkg::FILL_W-1:0]   fill_level,
  output logic                          busy_flag
);
  import ubtx_pkg::*;

  localparam int PTR_W   = $clog2(RING_DEPTH);
  localparam int CNT_W   = $clog2(MAX_PACKET + 1);
  localparam int MULTS   = ((1 << SENT_W) - 1) / MAX_PACKET;

  logic [DATA_W-1:0] tx_store [RING_DEPTH];
  logic [DATA_W-1:0] rd_data;
  logic [PTR_W-1:0]  write_ptr;
  logic [PTR_W-1:0]  read_ptr;
  logic              in_flight;
  logic              link_enabled;
  logic [CNT_W-1:0]  pkt_count;
  logic              acc;
  logic              zlp;

  // Captured input transaction.
  logic [FUNC_W-1:0] func_r;
  logic [DATA_W-1:0] data_r;
  logic              eow_r;
  logic [SENT_W-1:0] sent_r;
  logic              cfg_r;

  logic [PTR_W:0]        fill;
  logic [PTR_W+FILL_W:0] fill_ext;
  logic                  zlp_req;

  function automatic logic [PTR_W-1:0] ring_advance(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      link_enabled <= 1'b0;
    end else if (cfg_we) begin
      link_enabled <= cfg_link;
    end
  end

  // Capture of the input transaction.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= func;
      data_r <= data_byte;
      eow_r  <= end_of_write;
      sent_r <= sent_count;
      cfg_r  <= configured;
    end
  end

  // Ring memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.write) begin
      tx_store[write_ptr] <= data_r;
    end
    if (cmd.read) begin
      rd_data <= tx_store[read_ptr];
    end
  end

  // Pointers, busy flag, packet byte count and per-item flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      write_ptr <= '0;
      read_ptr  <= '0;
      in_flight <= 1'b0;
      pkt_count <= '0;
      acc       <= 1'b0;
      zlp       <= 1'b0;
    end else begin
      if (cmd.write) begin
        write_ptr <= ring_advance(write_ptr);
      end
      if (cmd.read) begin
        read_ptr  <= ring_advance(read_ptr);
        pkt_count <= pkt_count + CNT_W'(1);
      end else if (cmd.start_tx) begin
        pkt_count <= '0;
      end
      if (cmd.start_tx) begin
        in_flight <= 1'b1;
      end else if (cmd.clear_busy) begin
        in_flight <= 1'b0;
      end
      if (cmd.load) begin
        acc <= 1'b0;
        zlp <= 1'b0;
      end else begin
        if (cmd.write) begin
          acc <= 1'b1;
        end
        if (cmd.mark_zlp) begin
          zlp <= 1'b1;
        end
      end
    end
  end

  // Queued byte count, wrapped around the ring.
  always_comb begin
    if (write_ptr >= read_ptr) begin
      fill = {1'b0, write_ptr} - {1'b0, read_ptr};
    end else begin
      fill = {1'b0, write_ptr} + (PTR_W + 1)'(RING_DEPTH) - {1'b0, read_ptr};
    end
    fill_ext = {{FILL_W{1'b0}}, fill};
  end

  // Sent count equal to a nonzero multiple of the packet size.
  always_comb begin
    zlp_req = 1'b0;
    for (int k = 1; k <= MULTS; k++) begin
      if (sent_r == SENT_W'(k * MAX_PACKET)) begin
        zlp_req = 1'b1;
      end
    end
  end

  // Status toward the controller.
  always_comb begin
    stat.func      = func_r;
    stat.link_ok   = link_enabled & cfg_r;
    stat.full      = (ring_advance(write_ptr) == read_ptr);
    stat.empty     = (write_ptr == read_ptr);
    stat.eow       = eow_r;
    stat.zlp_req   = zlp_req;
    stat.in_flight = in_flight;
    stat.cfg       = cfg_r;
    stat.last_byte = (pkt_count == CNT_W'(MAX_PACKET)) || (read_ptr == write_ptr);
  end

  // Result fields.
  assign accepted    = acc;
  assign pkt_valid   = cmd.show_pkt;
  assign pkt_byte    = cmd.show_pkt ? rd_data : '0;
  assign zero_length = cmd.show_pkt ? 1'b0 : zlp;
  assign last        = cmd.show_pkt ? stat.last_byte : 1'b1;
  assign fill_level  = fill_ext[FILL_W-1:0];
  assign busy_flag   = in_flight;

endmodule

FILE: rtl/ubtx_ctrl.sv
// Controller state machine of the packetizer.
module ubtx_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  ubtx_pkg::ubtx_stat_t stat,
  output ubtx_pkg::ubtx_cmd_t  cmd
);
  import ubtx_pkg::*;

  state_t state;
  state_t state_next;
  logic   push_ok;
  logic   is_zlp;
  logic   kick;
  logic   tx_go;

  // Decision for the captured item.
  always_comb begin
    push_ok = (stat.func == FN_PUSH) && stat.link_ok && !stat.full;
    is_zlp  = (stat.func == FN_DONE) && stat.zlp_req;
    kick    = ((stat.func == FN_PUSH) && stat.link_ok && (stat.full || stat.eow)) ||
              ((stat.func == FN_DONE) && !stat.zlp_req) ||
              (stat.func == FN_KICK);
    tx_go   = kick && stat.cfg && ((stat.func == FN_DONE) || !stat.in_flight) &&
              (push_ok || !stat.empty);
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EVAL;
      end
      S_EVAL: begin
        if (is_zlp) state_next = S_STAT;
        else if (tx_go) state_next = S_READ;
        else state_next = S_STAT;
      end
      S_READ: state_next = S_SEND;
      S_SEND: begin
        if (out_ready) state_next = stat.last_byte ? S_IDLE : S_READ;
      end
      S_STAT: begin
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs and datapath commands.
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_EVAL: begin
        cmd.mark_zlp   = is_zlp;
        cmd.write      = push_ok;
        cmd.clear_busy = (stat.func == FN_DONE) && !is_zlp;
        cmd.start_tx   = !is_zlp && tx_go;
      end
      S_READ: cmd.read = 1'b1;
      S_SEND: begin
        cmd.show_pkt = 1'b1;
        out_valid    = 1'b1;
      end
      S_STAT: out_valid = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule

FILE: rtl/ubtx_chk.sv
// Port-level checker of the packetizer and its bind to the top level.
module ubtx_chk (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_pkt_valid,
  input logic out_zero_length,
  input logic out_last,
  input logic out_busy
);

  // An item is never taken while a result is still offered.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while a result is pending");

  // The input closes right after a taken item.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after an accepted transaction");

  // A packet byte that is not the last keeps the input closed.
  a_packet_continues: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_pkt_valid && !out_last) |=> !in_ready)
    else $error("packet cut short");

  // A zero-length request is a single status result.
  a_zlp_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_zero_length) |-> (!out_pkt_valid && out_last && out_busy) ||
                                       (!out_pkt_valid && out_last && !out_busy))
    else $error("malformed zero-length request");

  // Every packet byte is sent with a transfer in flight.
  a_busy_on_packet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_pkt_valid) |-> out_busy)
    else $error("packet byte without a transfer in flight");

endmodule

bind usb_bulk_in_tx_packetizer ubtx_chk u_chk (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_pkt_valid   (out_ch.pkt_valid),
  .out_zero_length (out_ch.zero_length),
  .out_last        (out_ch.last),
  .out_busy        (out_ch.busy_flag)
);
